[rtl/ptw_pkg.sv]
// Shared types and constants for the page table walker.
`timescale 1ns / 1ps
package ptw_pkg;

  localparam logic [1:0] OP_MAP       = 2'd0;
  localparam logic [1:0] OP_UNMAP     = 2'd1;
  localparam logic [1:0] OP_TRANSLATE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_NOMEM    = 3'd2;
  localparam logic [2:0] ST_UNMAPPED = 3'd3;
  localparam logic [2:0] ST_MAPPED   = 3'd4;
  localparam logic [2:0] ST_LARGE    = 3'd5;

  localparam int PG_PRESENT_BIT = 0;
  localparam int PG_WRITE_BIT   = 1;
  localparam int PG_USER_BIT    = 2;
  localparam int PG_LARGE_BIT   = 7;
  localparam logic [63:0] PG_ADDR   = 64'h000F_FFFF_FFFF_F000;
  localparam logic [11:0] PG_OFFSET = 12'hFFF;
  localparam int IDX_BITS = 9;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RDREQ = 8'b0000_0010,
    S_RDWT  = 8'b0000_0100,
    S_EVAL  = 8'b0000_1000,
    S_CLEAR = 8'b0001_0000,
    S_LEAF  = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_INIT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] virt_addr;
    logic [51:0] phys_addr;
    logic [63:0] map_flags;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [51:0] translated_addr;
    logic [63:0] entry_flags;
    logic        flush_request;
  } rsp_t;

endpackage

[rtl/ptw_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[rtl/ptw_walker.sv]
// Walk sequencer: address checks, table reads, builds, leaf update.
`timescale 1ns / 1ps
module ptw_walker import ptw_pkg::*; #(
  parameter int TABLE_PAGES = 64,
  parameter int LEVELS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [6:0] limit,
  input  logic       start,
  input  req_t       req,
  output logic       busy,
  output logic       done,
  output rsp_t       rsp,
  input  logic       rsp_taken
);
  localparam int PW = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int AW = PW + IDX_BITS;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TOP = 12 + 9 * LEVELS - 1;
  localparam int UW = (PW + 1 > 7) ? PW + 1 : 7;
  localparam logic [UW-1:0] PAGES_U = UW'(TABLE_PAGES);

  state_t state;
  req_t   r;
  logic [LW-1:0]      level;
  logic [PW-1:0]      page;
  logic [UW-1:0]      used;
  logic [IDX_BITS:0]  clr;
  logic               wipe;
  logic [AW-1:0]      addr;
  logic               we;
  logic [63:0]        wdata, rdata;

  ptw_ram #(.WIDTH(64), .DEPTH(TABLE_PAGES * 512)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [63-TOP:0] hi;
  logic canon, bad;
  logic [IDX_BITS-1:0] idx;
  logic [63:0] want, e_new, leaf;
  logic [UW-1:0] lim;
  logic [39:0] e_pfn;
  logic [PW-1:0] e_page;

  always_comb begin
    hi = r.virt_addr[63:TOP];
    canon = (hi == '0) || (hi == '1);
    unique case (r.operation)
      OP_MAP:       bad = !canon || (r.virt_addr[11:0] != 12'd0) ||
                          (r.phys_addr[11:0] != 12'd0);
      OP_UNMAP:     bad = !canon || (r.virt_addr[11:0] != 12'd0);
      OP_TRANSLATE: bad = !canon;
      default:      bad = 1'b1;
    endcase
    idx = r.virt_addr[12 + 9 * level +: IDX_BITS];
    want = 64'h3 | (r.map_flags & 64'h4);
    lim = (UW'(limit) > PAGES_U) ? PAGES_U : UW'(limit);
    e_pfn = rdata[51:12];
    e_page = (e_pfn >= 40'(TABLE_PAGES)) ? '0 : e_pfn[PW-1:0];
    e_new = ((64'(used) << 12) & PG_ADDR) | want;
    leaf = ({12'd0, r.phys_addr} & PG_ADDR) | (r.map_flags & ~PG_ADDR) | 64'h1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      used  <= UW'(1);
      done  <= 1'b0;
      clr   <= '0;
      wipe  <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r <= req;
            level <= LW'(LEVELS - 1);
            page <= '0;
            rsp <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          if (bad) begin
            rsp.status <= ST_BAD;
            done <= 1'b1;
            state <= S_OUT;
          end else state <= S_RDREQ;
        end
        S_RDREQ: state <= S_RDWT;
        S_RDWT: state <= (level == '0) ? S_LEAF : S_EVAL;
        S_EVAL: begin
          if (!rdata[PG_PRESENT_BIT]) begin
            if (r.operation != OP_MAP) begin
              rsp.status <= ST_UNMAPPED; done <= 1'b1; state <= S_OUT;
            end else if (used >= lim) begin
              rsp.status <= ST_NOMEM; done <= 1'b1; state <= S_OUT;
            end else begin
              clr <= '0;
              state <= S_CLEAR;
            end
          end else if (rdata[PG_LARGE_BIT]) begin
            rsp.status <= ST_LARGE; done <= 1'b1; state <= S_OUT;
          end else begin
            page <= e_page;
            level <= level - LW'(1);
            state <= S_RDREQ;
          end
        end
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr[IDX_BITS]) begin
            if (wipe) begin
              wipe <= 1'b0;
              state <= S_IDLE;
            end else begin
              page <= used[PW-1:0];
              used <= used + UW'(1);
              level <= level - LW'(1);
              state <= S_RDREQ;
            end
          end
        end
        S_LEAF: begin
          if (!rdata[PG_PRESENT_BIT]) begin
            if (r.operation != OP_MAP) rsp.status <= ST_UNMAPPED;
          end else begin
            unique case (r.operation)
              OP_MAP:   rsp.status <= ST_MAPPED;
              OP_UNMAP: rsp.flush_request <= 1'b1;
              default: begin
                rsp.translated_addr <= (rdata[51:0] & PG_ADDR[51:0]) +
                                       {40'd0, r.virt_addr[11:0]};
                rsp.entry_flags <= rdata & ~PG_ADDR;
              end
            endcase
          end
          done <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp_taken) begin
            done <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    we = 1'b0;
    wdata = '0;
    addr = {page, idx};
    unique case (state)
      S_EVAL: begin
        if (r.operation == OP_MAP && rdata[PG_PRESENT_BIT] && !rdata[PG_LARGE_BIT]) begin
          we = 1'b1; wdata = rdata | want;
        end
      end
      S_CLEAR: begin
        if (clr[IDX_BITS]) begin
          we = !wipe; wdata = e_new;
        end else begin
          we = 1'b1;
          addr = {(wipe ? PW'(0) : used[PW-1:0]), clr[IDX_BITS-1:0]};
        end
      end
      S_LEAF: begin
        if (r.operation == OP_MAP && !rdata[PG_PRESENT_BIT]) begin
          we = 1'b1; wdata = leaf;
        end else if (r.operation == OP_UNMAP && rdata[PG_PRESENT_BIT]) begin
          we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_OUT) else $error("done outside output state");
  a_used_lim: assert property (@(posedge clk) disable iff (rst)
    used <= PAGES_U) else $error("page pool overrun");
  a_flush_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.flush_request) |-> rsp.status == ST_OK) else $error("flush on failure");
endmodule

[rtl/page_table_map_unmap_translate.sv]
// Top level of the four-level page table walker.
// Channel | Dir | Handshake      | Payload
// s_axis  | in  | tvalid/tready  | operation, virt_addr, phys_addr, map_flags
// m_axis  | out | tvalid/tready  | status, translated_addr, entry_flags, flush_request
// cfg     | in  | valid/ready    | table_page_limit
// A walk is an address check, then per level a table read (request, wait, evaluate),
// all through the single RAM port; a new request is taken only after the result.
// A bad address answers straight after the check; each table built adds a 512-entry clear.
// Reset is synchronous; after it the root page is cleared, with tready low.
// One request in flight; s_axis_tready stays low until the result is taken.
`timescale 1ns / 1ps
module page_table_map_unmap_translate import ptw_pkg::*; #(
  parameter int TABLE_PAGES = 64,
  parameter int LEVELS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[1:0], virt_addr[65:2], phys_addr[117:66], map_flags[181:118]
  input  logic [183:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], translated_addr[54:3], entry_flags[118:55], flush_request[119]
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data
);
  logic [6:0] limit;
  logic busy, done;
  req_t req;
  rsp_t rsp;

  always_ff @(posedge clk) begin
    if (rst) limit <= 7'd64;
    else if (cfg_valid) limit <= cfg_data;
  end

  assign cfg_ready = 1'b1;
  assign req.operation  = s_axis_tdata[1:0];
  assign req.virt_addr  = s_axis_tdata[65:2];
  assign req.phys_addr  = s_axis_tdata[117:66];
  assign req.map_flags  = s_axis_tdata[181:118];
  assign s_axis_tready = !busy;
  assign m_axis_tvalid = done;
  assign m_axis_tdata = {8'd0, rsp.flush_request, rsp.entry_flags,
                         rsp.translated_addr, rsp.status};

  ptw_walker #(.TABLE_PAGES(TABLE_PAGES), .LEVELS(LEVELS)) u_walker (
    .clk(clk), .rst(rst), .limit(limit),
    .start(s_axis_tvalid && !busy), .req(req),
    .busy(busy), .done(done), .rsp(rsp), .rsp_taken(m_axis_tready)
  );
endmodule

[dv/testbench.sv]
// Self-checking testbench for the page table walker: map, unmap and translate requests.
`timescale 1ns / 1ps
module testbench import ptw_pkg::*;;

  localparam int NPAGES = 64;
  localparam int NSLOTS = NPAGES * 512;
  localparam int WDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [63:0] PG_ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] PG_PRESENT = 64'h1;
  localparam logic [63:0] PG_WRITE = 64'h2;
  localparam logic [63:0] PG_USER = 64'h4;
  localparam logic [1:0] OP_ILLEGAL = 2'd3;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [183:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [6:0] cfg_data;

  page_table_map_unmap_translate u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  logic [63:0] tbl_mem [0:NSLOTS-1];
  int unsigned pages_used;
  int unsigned page_limit;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int unsigned mismatches;
  int unsigned send_gap;
  int unsigned recv_gap;
  bit no_idle;
  bit hold_go;
  bit hold_off;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_canonical(logic [63:0] va);
    logic [16:0] hi;
    hi = va[63:47];
    return (hi == '0) || (hi == '1);
  endfunction

  function automatic int slot_of(int unsigned page, logic [63:0] va, int lvl);
    int idx;
    idx = int'((va >> (12 + 9 * lvl)) & 64'd511);
    if (page >= NPAGES) page = 0;
    return int'(page * 512) + idx;
  endfunction

  function automatic logic [2:0] walk_path(logic [63:0] va, bit build, logic [63:0] want,
                                           output int leaf_slot);
    int unsigned page;
    int s;
    logic [63:0] e;
    page = 0;
    leaf_slot = 0;
    for (int lvl = 3; lvl > 0; lvl--) begin
      s = slot_of(page, va, lvl);
      e = tbl_mem[s];
      if (!e[0]) begin
        if (!build) return ST_UNMAPPED;
        if (pages_used >= ((page_limit > NPAGES) ? NPAGES : page_limit)) return ST_NOMEM;
        for (int k = 0; k < 512; k++) tbl_mem[pages_used * 512 + k] = '0;
        e = ((64'(pages_used) << 12) & PG_ADDR_MASK) | want;
        pages_used++;
        tbl_mem[s] = e;
      end else if (e[7]) begin
        return ST_LARGE;
      end else if (build) begin
        e = e | want;
        tbl_mem[s] = e;
      end
      page = int'((e & PG_ADDR_MASK) >> 12);
    end
    leaf_slot = slot_of(page, va, 0);
    return ST_OK;
  endfunction

  function automatic rsp_t predict_walk(req_t rq);
    rsp_t r;
    int slot;
    logic [63:0] e;
    logic [63:0] phys;
    r = '0;
    phys = {12'h0, rq.phys_addr};
    case (rq.operation)
      OP_MAP: begin
        if (phys[11:0] != 0 || !is_canonical(rq.virt_addr) || rq.virt_addr[11:0] != 0) begin
          r.status = ST_BAD;
        end else begin
          r.status = walk_path(rq.virt_addr, 1'b1,
                               PG_PRESENT | PG_WRITE | (rq.map_flags & PG_USER), slot);
          if (r.status == ST_OK) begin
            if (tbl_mem[slot][0]) r.status = ST_MAPPED;
            else tbl_mem[slot] = (phys & PG_ADDR_MASK) | (rq.map_flags & ~PG_ADDR_MASK)
                                 | PG_PRESENT;
          end
        end
      end
      OP_UNMAP: begin
        if (!is_canonical(rq.virt_addr) || rq.virt_addr[11:0] != 0) begin
          r.status = ST_BAD;
        end else begin
          r.status = walk_path(rq.virt_addr, 1'b0, '0, slot);
          if (r.status == ST_OK) begin
            if (!tbl_mem[slot][0]) begin
              r.status = ST_UNMAPPED;
            end else begin
              tbl_mem[slot] = '0;
              r.flush_request = 1'b1;
            end
          end
        end
      end
      OP_TRANSLATE: begin
        if (!is_canonical(rq.virt_addr)) begin
          r.status = ST_BAD;
        end else begin
          r.status = walk_path({rq.virt_addr[63:12], 12'h0}, 1'b0, '0, slot);
          if (r.status == ST_OK) begin
            e = tbl_mem[slot];
            if (!e[0]) begin
              r.status = ST_UNMAPPED;
            end else begin
              r.translated_addr = 52'((e & PG_ADDR_MASK) + {52'h0, rq.virt_addr[11:0]});
              r.entry_flags = e & ~PG_ADDR_MASK;
            end
          end
        end
      end
      default: r.status = ST_BAD;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    req_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      send_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rsps.push_back(predict_walk(pending_reqs.pop_front()));
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs[0];
          s_axis_tdata <= {2'b00, nxt.map_flags, nxt.phys_addr, nxt.virt_addr, nxt.operation};
          s_axis_tvalid <= 1'b1;
          send_gap <= no_idle ? 0 : $urandom_range(0, 9);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t got;
    rsp_t exp_r;
    int unsigned gap;
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      gap = recv_gap;
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[2:0];
        got.translated_addr = m_axis_tdata[54:3];
        got.entry_flags = m_axis_tdata[118:55];
        got.flush_request = m_axis_tdata[119];
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_rsps.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d ta=%h fl=%h fr=%b got st=%0d ta=%h fl=%h fr=%b",
                       exp_r.status, exp_r.translated_addr, exp_r.entry_flags,
                       exp_r.flush_request, got.status, got.translated_addr,
                       got.entry_flags, got.flush_request);
          end
        end
        gap = no_idle ? 0 : $urandom_range(0, 9);
      end else if (gap > 0) begin
        gap = gap - 1;
      end
      recv_gap <= gap;
      m_axis_tready <= (gap == 0) && !hold_off;
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pool_addr();
    logic [47:0] va;
    int i3;
    i3 = $urandom_range(0, 2);
    va[47:39] = (i3 == 2) ? 9'd511 : 9'(i3);
    va[38:30] = $urandom_range(0, 1) ? 9'd2 : 9'd0;
    va[29:21] = $urandom_range(0, 1) ? 9'd3 : 9'd0;
    case ($urandom_range(0, 3))
      0: va[20:12] = 9'd0;
      1: va[20:12] = 9'd1;
      2: va[20:12] = 9'd2;
      default: va[20:12] = 9'd511;
    endcase
    va[11:0] = 12'h0;
    return {{16{va[47]}}, va};
  endfunction

  function automatic req_t random_req(int spread);
    req_t rq;
    int pick;
    logic [47:0] va;
    rq.phys_addr = 52'({$urandom(), $urandom()} & 64'h000F_FFFF_FFFF_F000);
    rq.map_flags = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      rq.operation = 2'($urandom_range(0, 3));
      rq.virt_addr = {$urandom(), $urandom()};
      rq.phys_addr = 52'({$urandom(), $urandom()});
      if ($urandom_range(0, 1)) rq.virt_addr[11:0] = 12'h0;
    end else begin
      if (pick < 15 + spread) begin
        va = 48'({$urandom(), $urandom()});
        va[11:0] = 12'h0;
        rq.virt_addr = {{16{va[47]}}, va};
      end else begin
        rq.virt_addr = pool_addr();
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) rq.operation = OP_MAP;
      else if (pick < 65) rq.operation = OP_UNMAP;
      else begin
        rq.operation = OP_TRANSLATE;
        rq.virt_addr[11:0] = 12'($urandom_range(0, 4095));
      end
    end
    return rq;
  endfunction

  function automatic req_t mk_req(logic [1:0] op, logic [63:0] va, logic [51:0] pa,
                                  logic [63:0] fl);
    req_t rq;
    rq.operation = op;
    rq.virt_addr = va;
    rq.phys_addr = pa;
    rq.map_flags = fl;
    return rq;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_rsps.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [6:0] v);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    page_limit = v;
  endtask

  task automatic push_random(int n, int spread);
    for (int i = 0; i < n; i++) pending_reqs.push_back(random_req(spread));
  endtask

  task automatic push_directed();
    logic [63:0] top;
    top = 64'hFFFF_FFFF_FFFF_F000;
    pending_reqs.push_back(mk_req(OP_MAP, 64'h0, 52'hF_FFFF_FFFF_F000, '1));
    pending_reqs.push_back(mk_req(OP_TRANSLATE, 64'hFFF, '0, '0));
    pending_reqs.push_back(mk_req(OP_MAP, 64'h0, 52'h1000, 64'h0));
    pending_reqs.push_back(mk_req(OP_UNMAP, 64'h0, '0, '0));
    pending_reqs.push_back(mk_req(OP_UNMAP, 64'h0, '0, '0));
    pending_reqs.push_back(mk_req(OP_TRANSLATE, 64'h0, '0, '0));
    pending_reqs.push_back(mk_req(OP_MAP, top, 52'h0, 64'h4));
    pending_reqs.push_back(mk_req(OP_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0));
    pending_reqs.push_back(mk_req(OP_MAP, 64'h0000_7FFF_FFFF_F000, 52'h2000, 64'h2));
    pending_reqs.push_back(mk_req(OP_MAP, 64'h0000_8000_0000_0000, 52'h0, 64'h0));
    pending_reqs.push_back(mk_req(OP_UNMAP, 64'hFFFF_7FFF_FFFF_F000, '0, '0));
    pending_reqs.push_back(mk_req(OP_TRANSLATE, 64'h8000_0000_0000_0000, '0, '0));
    pending_reqs.push_back(mk_req(OP_MAP, 64'h1001, 52'h3000, 64'h0));
    pending_reqs.push_back(mk_req(OP_MAP, 64'h5000, 52'h3001, 64'h0));
    pending_reqs.push_back(mk_req(OP_UNMAP, 64'h5800, '0, '0));
    pending_reqs.push_back(mk_req(OP_ILLEGAL, '1, '1, '1));
    pending_reqs.push_back(mk_req(OP_ILLEGAL, '0, '0, '0));
    pending_reqs.push_back(mk_req(OP_UNMAP, top, '0, '0));
    pending_reqs.push_back(mk_req(OP_TRANSLATE, top, '0, '0));
  endtask

  initial begin
    tbl_mem = '{default: '0};
    pages_used = 1;
    page_limit = 64;
    mismatches = 0;
    no_idle = 1'b0;
    hold_go = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_limit(7'd1);
    push_directed();
    push_random(80, 0);
    write_limit(7'd4);
    push_directed();
    push_random(150, 0);
    write_limit(7'd127);
    push_random(40, 0);
    do @(negedge clk);
    while (pending_reqs.size() > 30);
    hold_go = 1'b1;
    push_random(260, 5);
    write_limit(7'd64);
    no_idle = 1'b1;
    push_random(120, 0);
    wait_idle();
    no_idle = 1'b0;
    push_random(200, 30);
    write_limit(7'($urandom_range(1, 64)));
    push_random(150, 5);
    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
